/* rtl/rbst_pkg.sv */
`timescale 1ns / 1ps

package rbst_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned DW = 33;
    localparam int unsigned NW = 49;
    localparam int unsigned NAXES = 3;
    localparam logic signed [QW-1:0] T_MOST_NEG = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] T_MOST_POS = {1'b0, {(QW-1){1'b1}}};

    // one quotient bit per cell of the divider chain
    typedef struct packed {
        logic [NW-1:0] rem_lo;
        logic [NW-1:0] num_lo;
        logic [NW-1:0] quo_lo;
        logic          neg_lo;
        logic [NW-1:0] rem_hi;
        logic [NW-1:0] num_hi;
        logic [NW-1:0] quo_hi;
        logic          neg_hi;
        logic [QW-1:0] dmag;
        logic          par;
        logic          par_ok;
    } t_axis;

    typedef struct packed {
        logic                    valid;
        t_axis [NAXES-1:0]       ax;
    } t_beat;

endpackage

/* rtl/ray_box_slab_test_unit.sv */
`timescale 1ns / 1ps
// ray / axis-aligned box slab test
// slave channel: one beat carries a box (min and max corners) and a ray
// (origin, direction), twelve signed q16.16 words packed in s_axis_tdata,
// box_min_x in the lowest bits. master channel: one beat per input beat,
// m_axis_tdata = {entry_distance, hit}, zeros above bit 32.
// stages from accepted input beat to output beat valid: one setup stage,
// a chain of 49 divider cells each giving one quotient bit of all six slab
// distances, a saturate/order stage, an interval stage.
// throughput: one beat per cycle; the chain advances whenever the output
// register is empty or being taken.
// reset clears all valid flags; payload in flight is dropped.
// a stall on m_axis_tready freezes the whole chain, and s_axis_tready falls
// until the output beat is taken.
module ray_box_slab_test_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // box_min_x..z, box_max_x..z, ray_origin_x..z, ray_dir_x..z
    input  logic [383:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // hit, entry_distance, zero pad
    output logic [39:0]   m_axis_tdata
);

    logic w_en;
    rbst_pkg::t_beat w_chain [rbst_pkg::NW+1];
    rbst_pkg::t_beat r_in;
    rbst_pkg::t_beat n_in;

    logic                           r_s1_valid;
    logic [rbst_pkg::NAXES-1:0]     r_s1_par;
    logic [rbst_pkg::NAXES-1:0]     r_s1_ok;
    logic signed [rbst_pkg::QW-1:0] r_s1_near [rbst_pkg::NAXES];
    logic signed [rbst_pkg::QW-1:0] r_s1_far [rbst_pkg::NAXES];

    logic                           r_out_valid;
    logic                           r_out_hit;
    logic signed [rbst_pkg::QW-1:0] r_out_dist;

    assign w_en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        logic signed [rbst_pkg::QW-1:0] lo;
        logic signed [rbst_pkg::QW-1:0] hi;
        logic signed [rbst_pkg::QW-1:0] org;
        logic signed [rbst_pkg::QW-1:0] dir;
        logic signed [rbst_pkg::DW-1:0] dl;
        logic signed [rbst_pkg::DW-1:0] dh;
        logic [rbst_pkg::DW-1:0]        ml;
        logic [rbst_pkg::DW-1:0]        mh;
        n_in = '0;
        n_in.valid = s_axis_tvalid;
        for (int a = 0; a < rbst_pkg::NAXES; a++) begin
            lo  = s_axis_tdata[32*a +: 32];
            hi  = s_axis_tdata[32*(a+3) +: 32];
            org = s_axis_tdata[32*(a+6) +: 32];
            dir = s_axis_tdata[32*(a+9) +: 32];
            dl = {lo[rbst_pkg::QW-1], lo} - {org[rbst_pkg::QW-1], org};
            dh = {hi[rbst_pkg::QW-1], hi} - {org[rbst_pkg::QW-1], org};
            ml = dl[rbst_pkg::DW-1] ? -dl : dl;
            mh = dh[rbst_pkg::DW-1] ? -dh : dh;
            n_in.ax[a].num_lo = {ml, 16'd0};
            n_in.ax[a].num_hi = {mh, 16'd0};
            n_in.ax[a].neg_lo = dl[rbst_pkg::DW-1] ^ dir[rbst_pkg::QW-1];
            n_in.ax[a].neg_hi = dh[rbst_pkg::DW-1] ^ dir[rbst_pkg::QW-1];
            n_in.ax[a].dmag = dir[rbst_pkg::QW-1] ? -dir : dir;
            n_in.ax[a].par = (dir == '0);
            n_in.ax[a].par_ok = !(org < lo || org > hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= n_in.valid;
        end
        if (w_en) begin
            r_in.ax <= n_in.ax;
        end
    end

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < rbst_pkg::NW; g++) begin : g_cell
        rbst_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    function automatic logic signed [rbst_pkg::QW-1:0] sat_q(
        input logic [rbst_pkg::NW-1:0] mag,
        input logic                    neg
    );
        logic big;
        big = (mag[rbst_pkg::NW-1:rbst_pkg::QW-1] != '0);
        if (neg) begin
            if (big) begin
                sat_q = rbst_pkg::T_MOST_NEG;
            end else begin
                sat_q = -$signed(mag[rbst_pkg::QW-1:0]);
            end
        end else begin
            sat_q = big ? rbst_pkg::T_MOST_POS : $signed(mag[rbst_pkg::QW-1:0]);
        end
    endfunction

    // saturate and put each axis pair in order
    always_ff @(posedge i_clk) begin
        logic signed [rbst_pkg::QW-1:0] d1;
        logic signed [rbst_pkg::QW-1:0] d2;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_chain[rbst_pkg::NW].valid;
        end
        if (w_en) begin
            for (int a = 0; a < rbst_pkg::NAXES; a++) begin
                d1 = sat_q(w_chain[rbst_pkg::NW].ax[a].quo_lo,
                           w_chain[rbst_pkg::NW].ax[a].neg_lo);
                d2 = sat_q(w_chain[rbst_pkg::NW].ax[a].quo_hi,
                           w_chain[rbst_pkg::NW].ax[a].neg_hi);
                r_s1_near[a] <= (d1 > d2) ? d2 : d1;
                r_s1_far[a]  <= (d1 > d2) ? d1 : d2;
                r_s1_par[a]  <= w_chain[rbst_pkg::NW].ax[a].par;
                r_s1_ok[a]   <= w_chain[rbst_pkg::NW].ax[a].par_ok;
            end
        end
    end

    // narrow the interval axis by axis; a parallel axis only checks the origin
    always_ff @(posedge i_clk) begin
        logic signed [rbst_pkg::QW-1:0] t_en;
        logic signed [rbst_pkg::QW-1:0] t_ex;
        logic                           h;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_en) begin
            t_en = rbst_pkg::T_MOST_NEG;
            t_ex = rbst_pkg::T_MOST_POS;
            h = 1'b1;
            for (int a = 0; a < rbst_pkg::NAXES; a++) begin
                if (r_s1_par[a]) begin
                    if (!r_s1_ok[a]) h = 1'b0;
                end else begin
                    if (r_s1_near[a] > t_en) t_en = r_s1_near[a];
                    if (r_s1_far[a] < t_ex) t_ex = r_s1_far[a];
                    if (t_en > t_ex) h = 1'b0;
                end
            end
            r_out_hit  <= h;
            r_out_dist <= h ? t_en : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_dist, r_out_hit};

endmodule

/* rtl/rbst_div_cell.sv */
`timescale 1ns / 1ps

module rbst_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  rbst_pkg::t_beat i_beat,
    output rbst_pkg::t_beat o_beat
);

    rbst_pkg::t_beat r_beat;
    rbst_pkg::t_beat n_beat;

    // restoring division step: shift in next numerator bit, try subtract
    always_comb begin
        logic [rbst_pkg::NW:0] t_lo;
        logic [rbst_pkg::NW:0] t_hi;
        logic [rbst_pkg::NW-1:0] s_lo;
        logic [rbst_pkg::NW-1:0] s_hi;
        n_beat = i_beat;
        for (int a = 0; a < rbst_pkg::NAXES; a++) begin
            s_lo = {i_beat.ax[a].rem_lo[rbst_pkg::NW-2:0],
                    i_beat.ax[a].num_lo[rbst_pkg::NW-1]};
            s_hi = {i_beat.ax[a].rem_hi[rbst_pkg::NW-2:0],
                    i_beat.ax[a].num_hi[rbst_pkg::NW-1]};
            t_lo = {1'b0, s_lo} - {{(rbst_pkg::NW-rbst_pkg::QW+1){1'b0}}, i_beat.ax[a].dmag};
            t_hi = {1'b0, s_hi} - {{(rbst_pkg::NW-rbst_pkg::QW+1){1'b0}}, i_beat.ax[a].dmag};
            n_beat.ax[a].num_lo = {i_beat.ax[a].num_lo[rbst_pkg::NW-2:0], 1'b0};
            n_beat.ax[a].num_hi = {i_beat.ax[a].num_hi[rbst_pkg::NW-2:0], 1'b0};
            n_beat.ax[a].rem_lo = t_lo[rbst_pkg::NW] ? s_lo : t_lo[rbst_pkg::NW-1:0];
            n_beat.ax[a].rem_hi = t_hi[rbst_pkg::NW] ? s_hi : t_hi[rbst_pkg::NW-1:0];
            n_beat.ax[a].quo_lo = {i_beat.ax[a].quo_lo[rbst_pkg::NW-2:0], ~t_lo[rbst_pkg::NW]};
            n_beat.ax[a].quo_hi = {i_beat.ax[a].quo_hi[rbst_pkg::NW-2:0], ~t_hi[rbst_pkg::NW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_en) begin
            r_beat.ax <= n_beat.ax;
        end
    end

    assign o_beat = r_beat;

endmodule

/* dv/slab_checker.sv */
`timescale 1ns / 1ps

module slab_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // box_min_x..z, box_max_x..z, ray_origin_x..z, ray_dir_x..z
    input  logic [383:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, entry_distance, zero pad
    input  logic [39:0]  m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic              hit;
        logic signed [31:0] entry;
    } t_hit_result;

    t_hit_result hit_q[$];

    function automatic logic signed [31:0] word_at(logic [383:0] d, int idx);
        return d[idx*32 +: 32];
    endfunction

    function automatic longint clamp_q(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function automatic t_hit_result slab_hit(logic [383:0] d);
        t_hit_result r;
        longint t_in, t_out, lo, hi, org, dir, n1, n2, tmp;
        bit ok;
        t_in = -64'sd2147483648;
        t_out = 64'sd2147483647;
        ok = 1;
        for (int a = 0; a < 3 && ok; a++) begin
            lo = longint'(word_at(d, a));
            hi = longint'(word_at(d, 3 + a));
            org = longint'(word_at(d, 6 + a));
            dir = longint'(word_at(d, 9 + a));
            if (dir == 0) begin
                if (org < lo || org > hi) ok = 0;
            end else begin
                n1 = clamp_q(((lo - org) * 65536) / dir);
                n2 = clamp_q(((hi - org) * 65536) / dir);
                if (n1 > n2) begin
                    tmp = n1;
                    n1 = n2;
                    n2 = tmp;
                end
                if (n1 > t_in) t_in = n1;
                if (n2 < t_out) t_out = n2;
                if (t_in > t_out) ok = 0;
            end
        end
        r.hit = ok;
        r.entry = ok ? t_in[31:0] : 32'd0;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_hit_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                hit_q.insert(hit_q.size(), slab_hit(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (hit_q.size() == 0) begin
                    report_mismatch("output beat with nothing expected");
                end else begin
                    want = hit_q.pop_front();
                    if (m_axis_tdata[0] !== want.hit)
                        report_mismatch($sformatf("hit got %b want %b",
                            m_axis_tdata[0], want.hit));
                    if (m_axis_tdata[32:1] !== want.entry)
                        report_mismatch($sformatf("entry got %h want %h",
                            m_axis_tdata[32:1], want.entry));
                    if (m_axis_tdata[39:33] !== 7'd0)
                        report_mismatch("nonzero pad");
                end
            end
        end
        o_pending = hit_q.size();
    end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    int           fail_count;
    int           pending;
    int           idle_cycles;
    bit           calm;

    ray_box_slab_test_unit DUT (.*);

    slab_checker checker_inst (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return 32'($signed($urandom_range(0, 400)) - 200);
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [383:0] make_item(int style);
        logic [383:0] d;
        logic [31:0] a, b;
        int m;
        for (int k = 0; k < 3; k++) begin
            m = (style == 0) ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : 1);
            a = rand_coord(m);
            b = rand_coord(m);
            if (style != 0 && $urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
                d[k*32 +: 32] = b;
                d[(3+k)*32 +: 32] = a;
            end else begin
                d[k*32 +: 32] = a;
                d[(3+k)*32 +: 32] = b;
            end
            d[(6+k)*32 +: 32] = rand_coord(m);
            case ($urandom_range(0, 9))
                0: d[(9+k)*32 +: 32] = 32'd0;
                1: d[(9+k)*32 +: 32] = rand_coord($urandom_range(2, 4));
                2: d[(9+k)*32 +: 32] = $urandom();
                default: d[(9+k)*32 +: 32] = rand_coord(1);
            endcase
        end
        return d;
    endfunction

    task automatic send_beat(logic [383:0] d);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [383:0] fill_words(logic [31:0] w);
        return {12{w}};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int waited;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        calm = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_beat(fill_words(32'h0));
        send_beat(fill_words(32'hffff_ffff));
        send_beat(fill_words(32'h8000_0000));
        send_beat(fill_words(32'h7fff_ffff));
        // all parallel, origin inside
        send_beat({96'd0, 96'd0, {3{32'h0001_0000}}, {3{32'hffff_0000}}});
        // parallel, origin outside
        send_beat({96'd0, {3{32'h0005_0000}}, {3{32'h0001_0000}}, 96'd0});
        // normal hit along x, origin behind box
        send_beat({32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'hfff6_0000,
                   {3{32'h0001_0000}}, {3{32'hffff_0000}}});
        // origin inside, negative entry
        send_beat({{3{32'h0000_4000}}, 96'd0, {3{32'h0001_0000}}, {3{32'hffff_0000}}});
        // saturating quotients
        send_beat({{3{32'h0000_0001}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}},
                   {3{32'h8000_0000}}});
        send_beat({{3{32'hffff_ffff}}, {3{32'h7fff_ffff}}, {3{32'h7fff_ffff}},
                   {3{32'h8000_0000}}});
        // inverted box
        send_beat({{3{32'h0001_0000}}, 96'd0, {3{32'hffff_0000}}, {3{32'h0001_0000}}});
        send_beat({96'd0, 96'd0, {3{32'hffff_0000}}, {3{32'h0001_0000}}});
        for (int n = 0; n < 8; n++) send_beat(make_item(0));
        for (int n = 0; n < 1400; n++) begin
            calm = (n >= 600 && n < 800);
            send_beat(make_item($urandom_range(0, 5) == 0 ? 0 : 1));
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (pending != 0) @(posedge i_clk);
        waited = 0;
        while (waited < 60) begin
            @(posedge i_clk);
            waited++;
        end
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/rbst_pkg.sv
rtl/rbst_div_cell.sv
rtl/ray_box_slab_test_unit.sv
dv/slab_checker.sv
dv/testbench.sv
